// File: rtl/four_channel_tone_generator_assert.svh
// assertion macros for the tone generator
`ifndef FOUR_CHANNEL_TONE_GENERATOR_ASSERT_SVH
`define FOUR_CHANNEL_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FCTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FCTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fctg_pkg.sv
package fctg_pkg;

  localparam int PRESCALE_LONG  = 114;
  localparam int PRESCALE_SHORT = 28;

  localparam int PRESC_W = 7;
  localparam int CNT_W   = 10;
  localparam int MIX_W   = 7;

  localparam int P4_W  = 7;
  localparam int P5_W  = 8;
  localparam int P9_W  = 12;
  localparam int P17_W = 20;

  localparam logic [3:0] REG_GLOBAL  = 4'd8;
  localparam logic [3:0] REG_CONSOLE = 4'd9;

  localparam logic [CNT_W-1:0] FAST_RELOAD_EXTRA = 10'd3;
  localparam logic [CNT_W-1:0] LINK_LOW_RELOAD   = 10'd255;
  localparam logic [17:0]      PAIR_RELOAD_EXTRA = 18'd6;

  // global control bits
  localparam int GC_PRESCALE_LONG = 0;
  localparam int GC_HP1           = 1;
  localparam int GC_HP0           = 2;
  localparam int GC_LINK23        = 3;
  localparam int GC_LINK01        = 4;
  localparam int GC_FAST2         = 5;
  localparam int GC_FAST0         = 6;
  localparam int GC_POLY9         = 7;

  // channel control bits
  localparam int CTRL_TOGGLE_ALWAYS = 7;
  localparam int CTRL_POLY4         = 6;
  localparam int CTRL_SQUARE        = 5;
  localparam int CTRL_VOL_ONLY      = 4;

  typedef logic [CNT_W-1:0] cnt_t;

  // returns {square, output} after an underflow
  function automatic logic [1:0] chan_update(input logic [7:0] ctrl, input logic sq,
                                             input logic p4, input logic p5,
                                             input logic p9, input logic p17,
                                             input logic sel9);
    logic sq_n;
    logic co_n;
    sq_n = sq ^ (ctrl[CTRL_TOGGLE_ALWAYS] | p5);
    if (ctrl[CTRL_SQUARE]) begin
      co_n = sq_n;
    end else if (ctrl[CTRL_POLY4]) begin
      co_n = p4;
    end else if (sel9) begin
      co_n = p9;
    end else begin
      co_n = p17;
    end
    return {sq_n, co_n};
  endfunction

endpackage

// File: rtl/four_channel_tone_generator.sv
// a tick's result is registered in the output register, or in the skid entry if output is stalled
// throughput: one transaction per cycle while in_ready is high; register writes update state
// and give no result; a two-entry output buffer lets ticks keep flowing while one result
// waits; in_ready drops only when both entries are full
// reset (rst_n low, synchronous): counters, registers and out_valid clear, high-pass
// latches set to one, noise shift registers set to all ones, output buffer empty (data not reset)
module four_channel_tone_generator
  import fctg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [3:0]       in_reg_index,
  input  logic [7:0]       in_write_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MIX_W-1:0] out_mix_level,
  output logic [3:0]       out_channel_bits
);

`include "four_channel_tone_generator_assert.svh"

  logic [PRESC_W-1:0] presc_r, presc_nxt;
  cnt_t               cnt_r [4];
  cnt_t               cnt_nxt [4];
  logic [7:0]         freq_r [4];
  logic [7:0]         freq_nxt [4];
  logic [7:0]         ctrl_r [4];
  logic [7:0]         ctrl_nxt [4];
  logic [7:0]         gc_r, gc_nxt;
  logic               console_r, console_nxt;
  logic [3:0]         sq_r, sq_nxt;
  logic [3:0]         co_r, co_nxt;
  logic [1:0]         hp_r, hp_nxt;
  logic [P4_W-1:0]    p4_r, p4_nxt;
  logic [P5_W-1:0]    p5_r, p5_nxt;
  logic [P9_W-1:0]    p9_r, p9_nxt;
  logic [P17_W-1:0]   p17_r, p17_nxt;
  logic [MIX_W-1:0]   mix_nxt;

  logic [3:0]         p4_sel;
  logic [3:0]         p5_sel;
  logic [3:0]         p9_sel;
  logic [3:0]         p17_sel;

  logic               out_v_r, out_v_nxt;
  logic [MIX_W-1:0]   out_mix_r, out_mix_nxt;
  logic [3:0]         out_bits_r, out_bits_nxt;
  logic               skid_v_r, skid_v_nxt;
  logic [MIX_W-1:0]   skid_mix_r, skid_mix_nxt;
  logic [3:0]         skid_bits_r, skid_bits_nxt;

  logic acc;
  logic acc_tick;
  logic acc_write;
  logic pop;

  assign in_ready  = !skid_v_r;
  assign acc       = in_valid && in_ready;
  assign acc_tick  = acc && !in_mode;
  assign acc_write = acc && in_mode;
  assign pop       = out_v_r && out_ready;

  assign out_valid        = out_v_r;
  assign out_mix_level    = out_mix_r;
  assign out_channel_bits = out_bits_r;

  // noise taps seen by channels 0 to 3
  assign p4_sel  = p4_r[3:0];
  assign p5_sel  = p5_r[3:0];
  assign p9_sel  = p9_r[3:0];
  assign p17_sel = p17_r[3:0];

  // register writes, channel state update and mix level
  always_comb begin
    logic       tick;
    logic       fast;
    logic       linked;
    logic [1:0] lo;
    logic [1:0] hi;
    logic [1:0] upd;
    logic [17:0] pv;
    logic       gate;

    presc_nxt   = presc_r;
    cnt_nxt     = cnt_r;
    freq_nxt    = freq_r;
    ctrl_nxt    = ctrl_r;
    gc_nxt      = gc_r;
    console_nxt = console_r;
    sq_nxt      = sq_r;
    co_nxt      = co_r;
    hp_nxt      = hp_r;
    p4_nxt      = p4_r;
    p5_nxt      = p5_r;
    p9_nxt      = p9_r;
    p17_nxt     = p17_r;
    mix_nxt     = {{(MIX_W-3){1'b0}}, console_r, 2'b00};
    tick        = (presc_r == '0);
    fast        = 1'b0;
    linked      = 1'b0;
    lo          = 2'd0;
    hi          = 2'd1;
    upd         = 2'b00;
    pv          = '0;
    gate        = 1'b0;

    if (acc_write) begin
      if (in_reg_index == REG_GLOBAL) begin
        gc_nxt = in_write_value;
        if (!in_write_value[GC_HP0]) begin
          hp_nxt[0] = 1'b1;
        end
        if (!in_write_value[GC_HP1]) begin
          hp_nxt[1] = 1'b1;
        end
      end else if (in_reg_index == REG_CONSOLE) begin
        console_nxt = in_write_value[0];
      end else if (!in_reg_index[3]) begin
        if (in_reg_index[0]) begin
          ctrl_nxt[in_reg_index[2:1]] = in_write_value;
        end else begin
          freq_nxt[in_reg_index[2:1]] = in_write_value;
        end
      end
    end

    if (acc_tick) begin
      if (tick) begin
        presc_nxt = gc_r[GC_PRESCALE_LONG] ? PRESC_W'(PRESCALE_LONG - 1)
                                           : PRESC_W'(PRESCALE_SHORT - 1);
      end else begin
        presc_nxt = presc_r - 1'b1;
      end

      for (int p = 0; p < 2; p++) begin
        lo     = 2'(2 * p);
        hi     = 2'(2 * p + 1);
        fast   = (p == 0) ? gc_r[GC_FAST0] : gc_r[GC_FAST2];
        linked = (p == 0) ? gc_r[GC_LINK01] : gc_r[GC_LINK23];
        if (!linked) begin
          if (fast || tick) begin
            if (cnt_nxt[lo] == '0) begin
              cnt_nxt[lo] = {2'b00, freq_r[lo]} + (fast ? FAST_RELOAD_EXTRA : '0);
              upd = chan_update(ctrl_r[lo], sq_nxt[lo], p4_sel[lo], p5_sel[lo],
                                p9_sel[lo], p17_sel[lo], gc_r[GC_POLY9]);
              sq_nxt[lo] = upd[1];
              co_nxt[lo] = upd[0];
              if (p == 1 && gc_r[GC_HP0]) begin
                hp_nxt[0] = co_nxt[0];
              end
            end else begin
              cnt_nxt[lo] = cnt_nxt[lo] - 1'b1;
            end
          end
          if (tick) begin
            if (cnt_nxt[hi] == '0) begin
              cnt_nxt[hi] = {2'b00, freq_r[hi]};
              upd = chan_update(ctrl_r[hi], sq_nxt[hi], p4_sel[hi], p5_sel[hi],
                                p9_sel[hi], p17_sel[hi], gc_r[GC_POLY9]);
              sq_nxt[hi] = upd[1];
              co_nxt[hi] = upd[0];
              if (p == 1 && gc_r[GC_HP1]) begin
                hp_nxt[1] = co_nxt[1];
              end
            end else begin
              cnt_nxt[hi] = cnt_nxt[hi] - 1'b1;
            end
          end
        end else if (fast || tick) begin
          if (cnt_nxt[lo] == '0) begin
            cnt_nxt[lo] = LINK_LOW_RELOAD;
            upd = chan_update(ctrl_r[lo], sq_nxt[lo], p4_sel[lo], p5_sel[lo],
                              p9_sel[lo], p17_sel[lo], gc_r[GC_POLY9]);
            sq_nxt[lo] = upd[1];
            co_nxt[lo] = upd[0];
            if (cnt_nxt[hi] == '0) begin
              pv = {2'b00, freq_r[hi], freq_r[lo]} + PAIR_RELOAD_EXTRA;
              cnt_nxt[lo] = {2'b00, pv[7:0]};
              cnt_nxt[hi] = pv[17:8];
              upd = chan_update(ctrl_r[hi], sq_nxt[hi], p4_sel[hi], p5_sel[hi],
                                p9_sel[hi], p17_sel[hi], gc_r[GC_POLY9]);
              sq_nxt[hi] = upd[1];
              co_nxt[hi] = upd[0];
            end else begin
              cnt_nxt[hi] = cnt_nxt[hi] - 1'b1;
            end
          end else begin
            cnt_nxt[lo] = cnt_nxt[lo] - 1'b1;
          end
        end
      end

      p4_nxt  = {p4_r[3] ^ p4_r[4], p4_r[P4_W-1:1]};
      p5_nxt  = {p5_r[3] ^ p5_r[5], p5_r[P5_W-1:1]};
      p9_nxt  = {p9_r[3] ^ p9_r[7], p9_r[P9_W-1:1]};
      p17_nxt = {p17_r[3] ^ p17_r[6], p17_r[P17_W-1:1]};
    end

    for (int k = 0; k < 4; k++) begin
      gate = co_nxt[k];
      if (k < 2) begin
        gate = gate ^ hp_nxt[k];
      end
      gate = gate | ctrl_r[k][CTRL_VOL_ONLY];
      if (gate) begin
        mix_nxt = mix_nxt + {{(MIX_W-4){1'b0}}, ctrl_r[k][3:0]};
      end
    end
  end

  // two-entry output buffer
  always_comb begin
    out_v_nxt     = out_v_r;
    out_mix_nxt   = out_mix_r;
    out_bits_nxt  = out_bits_r;
    skid_v_nxt    = skid_v_r;
    skid_mix_nxt  = skid_mix_r;
    skid_bits_nxt = skid_bits_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt    = 1'b1;
        out_mix_nxt  = skid_mix_r;
        out_bits_nxt = skid_bits_r;
        skid_v_nxt   = 1'b0;
      end else if (acc_tick) begin
        out_v_nxt    = 1'b1;
        out_mix_nxt  = mix_nxt;
        out_bits_nxt = co_nxt;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (acc_tick) begin
      skid_v_nxt    = 1'b1;
      skid_mix_nxt  = mix_nxt;
      skid_bits_nxt = co_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r   <= '0;
      cnt_r     <= '{default: '0};
      freq_r    <= '{default: '0};
      ctrl_r    <= '{default: '0};
      gc_r      <= '0;
      console_r <= 1'b0;
      sq_r      <= '0;
      co_r      <= '0;
      hp_r      <= '1;
      p4_r      <= '1;
      p5_r      <= '1;
      p9_r      <= '1;
      p17_r     <= '1;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      presc_r   <= presc_nxt;
      cnt_r     <= cnt_nxt;
      freq_r    <= freq_nxt;
      ctrl_r    <= ctrl_nxt;
      gc_r      <= gc_nxt;
      console_r <= console_nxt;
      sq_r      <= sq_nxt;
      co_r      <= co_nxt;
      hp_r      <= hp_nxt;
      p4_r      <= p4_nxt;
      p5_r      <= p5_nxt;
      p9_r      <= p9_nxt;
      p17_r     <= p17_nxt;
      out_v_r   <= out_v_nxt;
      skid_v_r  <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mix_r   <= out_mix_nxt;
    out_bits_r  <= out_bits_nxt;
    skid_mix_r  <= skid_mix_nxt;
    skid_bits_r <= skid_bits_nxt;
  end

  `FCTG_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_v_r, out_v_r,
    "skid entry held while output register empty")
  `FCTG_ASSERT_NOW(a_mix_range, clk, rst_n, out_v_r, out_mix_r <= MIX_W'(64),
    "mix level above full scale")
  `FCTG_ASSERT_NEXT(a_write_no_result, clk, rst_n, acc_write && !out_v_r, !out_v_r,
    "register write produced a result")
  `FCTG_ASSERT_NOW(a_presc_range, clk, rst_n, 1'b1, presc_r < PRESC_W'(PRESCALE_LONG),
    "prescaler out of range")

endmodule
